// File: sv/nod_pkg.sv
// shared constants for the note and octave detector
package nod_pkg;

	localparam int NOTE_COUNT = 12;
	localparam int RSHIFT     = 24;
	localparam int IDX_W      = 4;
	localparam int MULT_W     = 12;
	localparam int ERR_W      = 20;

	localparam logic [IDX_W-1:0] NOTE_FIRST = 4'd0;
	localparam logic [IDX_W-1:0] NOTE_LAST  = 4'd11;

	localparam logic signed [ERR_W-1:0] ERR_MAX = 20'sd524287;
	localparam logic signed [ERR_W-1:0] ERR_MIN = -20'sd524288;

	// C1 in tenths of a hertz: q = floor(f * 10 / 327)
	localparam int C1_DHZ = 327;

	// first-octave note frequencies in centihertz, C1 through B1
	localparam longint unsigned NOTE_CHZ [NOTE_COUNT] = '{
		64'd3270, 64'd3465, 64'd3671, 64'd3889,
		64'd4120, 64'd4365, 64'd4625, 64'd4900,
		64'd5191, 64'd5500, 64'd5827, 64'd6174
	};

endpackage

// File: sv/note_and_octave_detector_core.sv
// top level of the nearest equal-tempered note detector
// Usage: drive tone_hz (whole hertz) and raise start; a request is taken at
// every rising edge where start is high and busy is low. busy is never
// raised, so one request can be taken in every cycle.
// The octave stage finds the power-of-two multiplier from f / 32.70, then a
// row of twelve note cells, C1 through B1, each forms f / note with a
// reciprocal multiply and hands the best error so far to its neighbor.
// A last stage checks C of the next octave and saturates the error.
// Pipeline: one octave stage, two stages in each of the twelve cells, one wrap
// stage; throughput is one result per cycle, set by the fully pipelined cell row.
// done is high for exactly one cycle with note_index, octave_multiplier and
// tuning_error; the receiver cannot hold it off, nothing is buffered.
// Reset clears every valid bit in the pipeline, so requests in flight are
// dropped and no done appears until new requests arrive.
module note_and_octave_detector_core #(
	parameter int FREQ_BITS     = 16,
	parameter int ERR_FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [FREQ_BITS-1:0]                tone_hz,
	output logic                                done,
	output logic [nod_pkg::IDX_W-1:0]           note_index,
	output logic [nod_pkg::MULT_W-1:0]          octave_multiplier,
	output logic signed [nod_pkg::ERR_W-1:0]    tuning_error
);

	localparam int NN      = nod_pkg::NOTE_COUNT;
	localparam int EFB     = ERR_FRAC_BITS;
	localparam int MW      = FREQ_BITS - 4;
	localparam int EW      = FREQ_BITS + EFB - 3;
	localparam int WW      = EW + 1;
	localparam int CW      = (WW > nod_pkg::ERR_W + 1) ? WW : nod_pkg::ERR_W + 1;
	localparam int MX      = (MW + 1 > nod_pkg::MULT_W) ? MW + 1 : nod_pkg::MULT_W;
	localparam int LATENCY = 2 * NN + 2;

	logic                       v_c        [NN+1];
	logic [FREQ_BITS-1:0]       f_c        [NN+1];
	logic [MW-1:0]              m_c        [NN+1];
	logic signed [EW-1:0]       best_err_c [NN+1];
	logic [nod_pkg::IDX_W-1:0]  best_idx_c [NN+1];
	logic signed [EW-1:0]       err0_c     [NN+1];

	logic signed [WW-1:0]       wrap_err;
	logic [WW-1:0]              mag_wrap;
	logic [WW-1:0]              mag_best;
	logic                       wrap;
	logic signed [CW-1:0]       sel_err;
	logic signed [nod_pkg::ERR_W-1:0] sat_err;
	logic [MX-1:0]              sel_mult;
	logic [nod_pkg::IDX_W-1:0]  sel_idx;

	logic                       done_q;
	logic [nod_pkg::IDX_W-1:0]  note_index_q;
	logic [nod_pkg::MULT_W-1:0] octave_multiplier_q;
	logic signed [nod_pkg::ERR_W-1:0] tuning_error_q;

	assign busy = 1'b0;

	nod_octave #(
		.FREQ_BITS(FREQ_BITS)
	) u_octave (
		.clk    (clk),
		.arst_n (arst_n),
		.v_in   (start && !busy),
		.f_in   (tone_hz),
		.v_out  (v_c[0]),
		.f_out  (f_c[0]),
		.m_out  (m_c[0])
	);

	assign best_err_c[0] = '0;
	assign best_idx_c[0] = nod_pkg::NOTE_FIRST;
	assign err0_c[0]     = '0;

	for (genvar i = 0; i < NN; i++) begin : g_cell
		nod_cell #(
			.FREQ_BITS     (FREQ_BITS),
			.ERR_FRAC_BITS (ERR_FRAC_BITS),
			.NOTE          (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.v_in         (v_c[i]),
			.f_in         (f_c[i]),
			.m_in         (m_c[i]),
			.best_err_in  (best_err_c[i]),
			.best_idx_in  (best_idx_c[i]),
			.err0_in      (err0_c[i]),
			.v_out        (v_c[i+1]),
			.f_out        (f_c[i+1]),
			.m_out        (m_c[i+1]),
			.best_err_out (best_err_c[i+1]),
			.best_idx_out (best_idx_c[i+1]),
			.err0_out     (err0_c[i+1])
		);
	end

	// C error against the doubled multiplier is the C1 error less one more M
	always_comb begin
		wrap_err = WW'(err0_c[NN]) - $signed(WW'({m_c[NN], {EFB{1'b0}}}));
		mag_wrap = wrap_err[WW-1] ? WW'(-wrap_err) : WW'(wrap_err);
		mag_best = best_err_c[NN][EW-1] ? WW'(-WW'(best_err_c[NN]))
		                                : WW'(best_err_c[NN]);
		wrap     = (mag_wrap < mag_best);
		if (wrap) begin
			sel_err  = CW'(wrap_err);
			sel_idx  = nod_pkg::NOTE_FIRST;
			sel_mult = MX'({m_c[NN], 1'b0});
		end else begin
			sel_err  = CW'(best_err_c[NN]);
			sel_idx  = best_idx_c[NN];
			sel_mult = MX'(m_c[NN]);
		end
		priority if (sel_err > CW'(nod_pkg::ERR_MAX)) begin
			sat_err = nod_pkg::ERR_MAX;
		end else if (sel_err < CW'(nod_pkg::ERR_MIN)) begin
			sat_err = nod_pkg::ERR_MIN;
		end else begin
			sat_err = nod_pkg::ERR_W'(sel_err);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_c[NN];
		end
	end

	always_ff @(posedge clk) begin
		note_index_q        <= sel_idx;
		octave_multiplier_q <= sel_mult[nod_pkg::MULT_W-1:0];
		tuning_error_q      <= sat_err;
	end

	assign done              = done_q;
	assign note_index        = note_index_q;
	assign octave_multiplier = octave_multiplier_q;
	assign tuning_error      = tuning_error_q;

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("done without a request at the expected latency");

	a_note_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (note_index <= nod_pkg::NOTE_LAST))
		else $error("note index out of range");

	a_mult_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0(octave_multiplier))
		else $error("octave multiplier not a power of two");

	a_wrap_is_c: assert property (@(posedge clk) disable iff (!arst_n)
		(v_c[NN] && wrap) |=> (done && note_index == nod_pkg::NOTE_FIRST))
		else $error("wrap to next octave did not select C");

endmodule

// File: sv/nod_octave.sv
// octave multiplier stage: largest power of two not above f / 32.70
module nod_octave #(
	parameter int FREQ_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 v_in,
	input  logic [FREQ_BITS-1:0] f_in,
	output logic                 v_out,
	output logic [FREQ_BITS-1:0] f_out,
	output logic [FREQ_BITS-5:0] m_out
);

	localparam int MW = FREQ_BITS - 4;
	localparam int TW = FREQ_BITS + 4;

	logic [TW-1:0] f10;
	logic [MW-1:0] ge;
	logic [MW-1:0] m_nxt;
	logic          v_s1;
	logic [FREQ_BITS-1:0] f_s1;
	logic [MW-1:0] m_s1;

	assign f10 = TW'({f_in, 3'b000}) + TW'({f_in, 1'b0});

	// thermometer of threshold hits, then keep its top bit
	always_comb begin
		for (int k = 0; k < MW; k++) begin
			ge[k] = (f10 >= (TW'(nod_pkg::C1_DHZ) << k));
		end
		m_nxt = ge & ~(ge >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		f_s1 <= f_in;
		m_s1 <= m_nxt;
	end

	assign v_out = v_s1;
	assign f_out = f_s1;
	assign m_out = m_s1;

endmodule

// File: sv/nod_cell.sv
// one note cell: ratio by reciprocal multiply, then keep the smaller error
module nod_cell #(
	parameter int FREQ_BITS     = 16,
	parameter int ERR_FRAC_BITS = 8,
	parameter int NOTE          = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  v_in,
	input  logic [FREQ_BITS-1:0]                  f_in,
	input  logic [FREQ_BITS-5:0]                  m_in,
	input  logic signed [FREQ_BITS+ERR_FRAC_BITS-4:0] best_err_in,
	input  logic [nod_pkg::IDX_W-1:0]             best_idx_in,
	input  logic signed [FREQ_BITS+ERR_FRAC_BITS-4:0] err0_in,
	output logic                                  v_out,
	output logic [FREQ_BITS-1:0]                  f_out,
	output logic [FREQ_BITS-5:0]                  m_out,
	output logic signed [FREQ_BITS+ERR_FRAC_BITS-4:0] best_err_out,
	output logic [nod_pkg::IDX_W-1:0]             best_idx_out,
	output logic signed [FREQ_BITS+ERR_FRAC_BITS-4:0] err0_out
);

	localparam int EFB = ERR_FRAC_BITS;
	localparam int MW  = FREQ_BITS - 4;
	localparam int EW  = FREQ_BITS + EFB - 3;
	localparam int RCW = nod_pkg::RSHIFT + EFB - 4;
	localparam int PW  = FREQ_BITS + RCW + 1;
	localparam longint unsigned CHZ = nod_pkg::NOTE_CHZ[NOTE];
	localparam longint unsigned RC_FULL =
		(((64'd1 << (nod_pkg::RSHIFT + EFB)) * 64'd100) + CHZ / 64'd2) / CHZ;
	localparam logic [RCW-1:0] RC = RCW'(RC_FULL);
	localparam logic [PW-1:0] HALF = PW'(1) << (nod_pkg::RSHIFT - 1);

	logic [PW-1:0]        prod;
	logic [EW-1:0]        ratio;
	logic signed [EW-1:0] cand;

	logic                 v_s1;
	logic [FREQ_BITS-1:0] f_s1;
	logic [MW-1:0]        m_s1;
	logic signed [EW-1:0] best_err_s1;
	logic [nod_pkg::IDX_W-1:0] best_idx_s1;
	logic signed [EW-1:0] err0_s1;
	logic signed [EW-1:0] cand_s1;

	logic [EW-1:0]        mag_cand;
	logic [EW-1:0]        mag_best;
	logic                 take;
	logic signed [EW-1:0] err0_nxt;

	logic                 v_s2;
	logic [FREQ_BITS-1:0] f_s2;
	logic [MW-1:0]        m_s2;
	logic signed [EW-1:0] best_err_s2;
	logic [nod_pkg::IDX_W-1:0] best_idx_s2;
	logic signed [EW-1:0] err0_s2;

	// ratio rounds half up, error against the octave multiplier
	assign prod  = PW'(f_in) * PW'(RC) + HALF;
	assign ratio = prod[PW-1:nod_pkg::RSHIFT];
	assign cand  = $signed(ratio) - $signed(EW'({m_in, {EFB{1'b0}}}));

	always_comb begin
		mag_cand = cand_s1[EW-1] ? EW'(-cand_s1) : EW'(cand_s1);
		mag_best = best_err_s1[EW-1] ? EW'(-best_err_s1) : EW'(best_err_s1);
		if (NOTE == 0) begin
			take     = 1'b1;
			err0_nxt = cand_s1;
		end else begin
			take     = (mag_cand < mag_best);
			err0_nxt = err0_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		f_s1        <= f_in;
		m_s1        <= m_in;
		best_err_s1 <= best_err_in;
		best_idx_s1 <= best_idx_in;
		err0_s1     <= err0_in;
		cand_s1     <= cand;

		f_s2        <= f_s1;
		m_s2        <= m_s1;
		err0_s2     <= err0_nxt;
		if (take) begin
			best_err_s2 <= cand_s1;
			best_idx_s2 <= nod_pkg::IDX_W'(NOTE);
		end else begin
			best_err_s2 <= best_err_s1;
			best_idx_s2 <= best_idx_s1;
		end
	end

	assign v_out        = v_s2;
	assign f_out        = f_s2;
	assign m_out        = m_s2;
	assign best_err_out = best_err_s2;
	assign best_idx_out = best_idx_s2;
	assign err0_out     = err0_s2;

endmodule

// File: verif/tb_note_and_octave_detector_core.sv
// testbench for the note and octave detector: directed and random tones against a predictor
module tb_note_and_octave_detector_core;

	localparam int FREQ_W     = 16;
	localparam int FRAC_W     = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int LATENCY    = 26;

	typedef struct packed {
		logic [FREQ_W-1:0]                tone;
		logic [nod_pkg::IDX_W-1:0]        note;
		logic [nod_pkg::MULT_W-1:0]       mult;
		logic signed [nod_pkg::ERR_W-1:0] err;
	} note_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             start = 1'b0;
	logic [FREQ_W-1:0]                tone_hz = '0;
	logic                             busy;
	logic                             done;
	logic [nod_pkg::IDX_W-1:0]        note_index;
	logic [nod_pkg::MULT_W-1:0]       octave_multiplier;
	logic signed [nod_pkg::ERR_W-1:0] tuning_error;

	note_result_t pending_notes [$];
	int           mismatch_count = 0;
	int           quiet_cycles = 0;
	int           idle_pct = 0;

	note_and_octave_detector_core #(
		.FREQ_BITS(FREQ_W),
		.ERR_FRAC_BITS(FRAC_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.tone_hz(tone_hz),
		.done(done),
		.note_index(note_index),
		.octave_multiplier(octave_multiplier),
		.tuning_error(tuning_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// f / note in fixed point, rounded half up
	function automatic longint note_ratio(logic [FREQ_W-1:0] f, int n);
		longint unsigned chz;
		longint unsigned rc;
		chz = nod_pkg::NOTE_CHZ[n];
		rc = (((64'd1 << (nod_pkg::RSHIFT + FRAC_W)) * 100) + chz / 2) / chz;
		return longint'((64'(f) * rc + (64'd1 << (nod_pkg::RSHIFT - 1)))
			>> nod_pkg::RSHIFT);
	endfunction

	function automatic longint unsigned err_mag(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	function automatic note_result_t predict_note(logic [FREQ_W-1:0] f);
		note_result_t     r;
		longint unsigned  q;
		longint unsigned  m;
		longint           best;
		longint           cand;
		int               best_n;
		q = (64'(f) * 100) / 3270;
		m = 0;
		while (q != 0) begin
			m = (m == 0) ? 1 : (m << 1);
			q = q >> 1;
		end
		best_n = 0;
		best = note_ratio(f, 0) - longint'(m << FRAC_W);
		for (int n = 1; n < nod_pkg::NOTE_COUNT; n++) begin
			cand = note_ratio(f, n) - longint'(m << FRAC_W);
			if (err_mag(cand) < err_mag(best)) begin
				best = cand;
				best_n = n;
			end
		end
		// C of the next octave wins only when strictly closer
		cand = note_ratio(f, 0) - longint'((m << 1) << FRAC_W);
		if (err_mag(cand) < err_mag(best)) begin
			best = cand;
			best_n = 0;
			m = m << 1;
		end
		if (best > longint'(nod_pkg::ERR_MAX))
			best = longint'(nod_pkg::ERR_MAX);
		if (best < longint'(nod_pkg::ERR_MIN))
			best = longint'(nod_pkg::ERR_MIN);
		r.tone = f;
		r.note = nod_pkg::IDX_W'(best_n);
		r.mult = nod_pkg::MULT_W'(m);
		r.err  = nod_pkg::ERR_W'(best);
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [FREQ_W-1:0] f, longint got, longint want);
		$display("%0t: tone %0d hz: %s is %0d, expected %0d", $time, f, field, got, want);
		mismatch_count++;
	endtask

	// request tracking and result checking, all sampled at the rising edge
	always @(posedge clk) begin
		note_result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_notes.size() == 0) begin
					report_mismatch("unexpected result, note", '0, note_index, -1);
				end else begin
					want = pending_notes.pop_front();
					if (note_index !== want.note)
						report_mismatch("note_index", want.tone, note_index, want.note);
					if (octave_multiplier !== want.mult)
						report_mismatch("octave_multiplier", want.tone, octave_multiplier, want.mult);
					if (tuning_error !== want.err)
						report_mismatch("tuning_error", want.tone, tuning_error, want.err);
				end
			end
			if (start && !busy)
				pending_notes.push_back(predict_note(tone_hz));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request or result for %0d cycles", $time, IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_tone(logic [FREQ_W-1:0] f);
		start <= 1'b1;
		tone_hz <= f;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_notes.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [FREQ_W-1:0] clamp_tone(longint v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return '1;
		return FREQ_W'(v);
	endfunction

	// change the idle mix now and then so quiet stretches alternate with busy ones
	task automatic pick_idle(int i);
		int sel;
		if (i % 64 == 0) begin
			sel = $urandom_range(0, 2);
			idle_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 40;
		end
	endtask

	task automatic test_directed();
		logic [FREQ_W-1:0] tones [] = '{
			16'd0, 16'd1, 16'd32, 16'd33, 16'd35, 16'd37, 16'd39, 16'd41,
			16'd44, 16'd46, 16'd49, 16'd52, 16'd55, 16'd58, 16'd62, 16'd64,
			16'd65, 16'd66, 16'd261, 16'd440, 16'h5555, 16'haaaa, 16'h7fff,
			16'h8000, 16'hffff
		};
		idle_pct = 20;
		foreach (tones[i])
			send_tone(tones[i]);
	endtask

	// tones a few hertz around a note in a random octave
	task automatic test_near_notes(int count);
		int n;
		int k;
		for (int i = 0; i < count; i++) begin
			pick_idle(i);
			n = $urandom_range(0, nod_pkg::NOTE_COUNT - 1);
			k = $urandom_range(0, 10);
			send_tone(clamp_tone(longint'((nod_pkg::NOTE_CHZ[n] << k) / 100)
				+ longint'($urandom_range(0, 8)) - 4));
		end
	endtask

	// halfway between neighbor notes and around octave edges, where ties and the wrap to C live
	task automatic test_note_boundaries(int count);
		int               n;
		int               k;
		longint unsigned  upper;
		longint           f;
		for (int i = 0; i < count; i++) begin
			pick_idle(i);
			n = $urandom_range(0, nod_pkg::NOTE_COUNT - 1);
			k = $urandom_range(0, 10);
			if ($urandom_range(0, 2) == 0) begin
				f = longint'((64'd327 << k) / 10);
			end else begin
				upper = (n == nod_pkg::NOTE_COUNT - 1) ? 2 * nod_pkg::NOTE_CHZ[0]
				                                       : nod_pkg::NOTE_CHZ[n + 1];
				f = longint'(((nod_pkg::NOTE_CHZ[n] + upper) << k) / 200);
			end
			send_tone(clamp_tone(f + longint'($urandom_range(0, 4)) - 2));
		end
	endtask

	task automatic test_full_range(int count);
		for (int i = 0; i < count; i++) begin
			pick_idle(i);
			send_tone(FREQ_W'($urandom_range(0, 65535)));
		end
	endtask

	// a burst, then hold off until every result is back
	task automatic test_pressure();
		idle_pct = 0;
		for (int i = 0; i < 25; i++)
			send_tone(FREQ_W'($urandom_range(0, 65535)));
		drain_results();
		@(posedge clk);
	endtask

	task automatic test_back_to_back(int count);
		idle_pct = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 2 == 0)
				send_tone(FREQ_W'($urandom()));
			else
				send_tone(clamp_tone(longint'(
					(nod_pkg::NOTE_CHZ[$urandom_range(0, nod_pkg::NOTE_COUNT - 1)]
					<< $urandom_range(0, 10)) / 100)));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_near_notes(600);
		test_pressure();
		test_note_boundaries(250);
		test_full_range(400);
		test_back_to_back(150);
		drain_results();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
